### hw/rtl/c2s_pkg.sv
// ----------------------------------------------------------------------------
// Cartesian to spherical converter package
// Shared types, fixed-point constants and the CORDIC arctangent table.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package c2s_pkg;

  localparam int COORD_BITS = 24;
  localparam int FRAC_BITS  = 38 - COORD_BITS;
  localparam int CDW        = 41;
  localparam int ANG_W      = 32;
  localparam int RANGE_W    = 29;
  localparam int AZ_W       = 24;
  localparam int POL_W      = 23;
  localparam int ATTR_W     = 16;

  localparam logic [ANG_W-1:0] HALF_TURN    = 32'h8000_0000;
  localparam logic [ANG_W-1:0] QUARTER_TURN = 32'h4000_0000;
  localparam logic [ANG_W-1:0] WRAP_LIMIT   = 32'hC000_0000;
  localparam logic [23:0]      ATAN_KINV    = 24'd10188014;
  localparam logic [27:0]      RANGE_SCALE  = 28'd260813150;
  localparam logic [23:0]      TURN_OUT     = 24'd9216000;

  localparam logic [ANG_W-1:0] ATAN_TAB [32] = '{
    32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756,
    32'd42667331,  32'd21354465,  32'd10679838,  32'd5340245,
    32'd2670163,   32'd1335087,   32'd667544,    32'd333772,
    32'd166886,    32'd83443,     32'd41722,     32'd20861,
    32'd10430,     32'd5215,      32'd2608,      32'd1304,
    32'd652,       32'd326,       32'd163,       32'd81,
    32'd41,        32'd20,        32'd10,        32'd5,
    32'd3,         32'd1,         32'd1,         32'd0
  };

  typedef struct packed {
    logic signed [COORD_BITS-1:0] coord_x;
    logic signed [COORD_BITS-1:0] coord_y;
    logic signed [COORD_BITS-1:0] coord_z;
    logic signed [ATTR_W-1:0]     in_reflectance;
    logic signed [ATTR_W-1:0]     in_amplitude;
    logic        [ATTR_W-1:0]     in_deviation;
    logic                         in_last_echo;
  } in_item_t;

  typedef struct packed {
    logic        [RANGE_W-1:0] range_out;
    logic        [AZ_W-1:0]    azimuth_out;
    logic        [POL_W-1:0]   polar_out;
    logic signed [ATTR_W-1:0]  out_reflectance;
    logic signed [ATTR_W-1:0]  out_amplitude;
    logic        [ATTR_W-1:0]  out_deviation;
    logic                      out_last_echo;
  } out_item_t;

  typedef struct packed {
    logic signed [ATTR_W-1:0] reflectance;
    logic signed [ATTR_W-1:0] amplitude;
    logic        [ATTR_W-1:0] deviation;
    logic                     last_echo;
  } attr_t;

  typedef struct packed {
    logic signed [CDW-1:0] x;
    logic signed [CDW-1:0] y;
    logic [ANG_W-1:0]      ang;
  } cvec_t;

  typedef struct packed {
    logic signed [COORD_BITS-1:0] coord_z;
    logic                         xy_zero;
    logic                         origin;
    attr_t                        attr;
  } side1_t;

  typedef struct packed {
    logic [ANG_W-1:0] az_ang;
    logic             xy_zero;
    logic             origin;
    attr_t            attr;
  } side2_t;

endpackage

### hw/rtl/c2s_cell.sv
// ----------------------------------------------------------------------------
// CORDIC vectoring cell
// One micro-rotation towards the x axis, registered, with a sideband that
// travels alongside the vector.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module c2s_cell
  import c2s_pkg::*;
#(
  parameter int K  = 0,
  parameter int SW = 1
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          en_i,
  input  logic          valid_i,
  input  cvec_t         vec_i,
  input  logic [SW-1:0] side_i,
  output logic          valid_o,
  output cvec_t         vec_o,
  output logic [SW-1:0] side_o
);

  localparam logic [ANG_W-1:0] ATAN_K = ATAN_TAB[K];

  logic signed [CDW-1:0] dx, dy;
  cvec_t                 vec_d, vec_q;
  logic [SW-1:0]         side_q;
  logic                  valid_q;

  assign dx = $signed(vec_i.y) >>> K;
  assign dy = $signed(vec_i.x) >>> K;

  always_comb begin
    if (!vec_i.y[CDW-1]) begin
      vec_d.x   = $signed(vec_i.x) + dx;
      vec_d.y   = $signed(vec_i.y) - dy;
      vec_d.ang = vec_i.ang + ATAN_K;
    end else begin
      vec_d.x   = $signed(vec_i.x) - dx;
      vec_d.y   = $signed(vec_i.y) + dy;
      vec_d.ang = vec_i.ang - ATAN_K;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      vec_q  <= vec_d;
      side_q <= side_i;
    end
  end

  assign valid_o = valid_q;
  assign vec_o   = vec_q;
  assign side_o  = side_q;

endmodule

### hw/rtl/c2s_chain.sv
// ----------------------------------------------------------------------------
// CORDIC vectoring chain
// A row of vectoring cells, one per iteration, passing the vector and its
// sideband along every cycle in which en_i is high.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module c2s_chain
  import c2s_pkg::*;
#(
  parameter int STAGES = 24,
  parameter int SW     = 1
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          en_i,
  input  logic          valid_i,
  input  cvec_t         vec_i,
  input  logic [SW-1:0] side_i,
  output logic          valid_o,
  output cvec_t         vec_o,
  output logic [SW-1:0] side_o
);

  logic          valid_w [STAGES+1];
  cvec_t         vec_w   [STAGES+1];
  logic [SW-1:0] side_w  [STAGES+1];

  assign valid_w[0] = valid_i;
  assign vec_w[0]   = vec_i;
  assign side_w[0]  = side_i;

  for (genvar k = 0; k < STAGES; k++) begin : g_cell
    c2s_cell #(
      .K  (k),
      .SW (SW)
    ) u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .en_i    (en_i),
      .valid_i (valid_w[k]),
      .vec_i   (vec_w[k]),
      .side_i  (side_w[k]),
      .valid_o (valid_w[k+1]),
      .vec_o   (vec_w[k+1]),
      .side_o  (side_w[k+1])
    );
  end

  assign valid_o = valid_w[STAGES];
  assign vec_o   = vec_w[STAGES];
  assign side_o  = side_w[STAGES];

endmodule

### hw/rtl/cartesian_to_spherical_degrees_core.sv
// ----------------------------------------------------------------------------
// Cartesian to spherical converter. Throughput one point per cycle, unless
// the skid register is full, through two chains of CORDIC_STAGES cells.
// A skid register decouples the output; reset clears all valid flags.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module cartesian_to_spherical_degrees_core
  import c2s_pkg::*;
#(
  parameter int CORDIC_STAGES = 24
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_stall_o,
  input  in_item_t  in_data_i,
  output logic      out_valid_o,
  input  logic      out_stall_i,
  output out_item_t out_data_o
);

  localparam int S1_W   = $bits(side1_t);
  localparam int S2_W   = $bits(side2_t);
  localparam int HI_W   = CDW - 1 - FRAC_BITS;
  localparam int HP_W   = HI_W + 28;
  localparam int LP_W   = FRAC_BITS + 28;
  localparam int DSUM_W = HP_W + 1;

  logic en;
  logic skid_valid_q;

  assign en         = !skid_valid_q;
  assign in_stall_o = skid_valid_q;

  // Entry stage: scale and fold the x-y vector into the right half-plane.
  logic signed [CDW-1:0] sx, sy;
  logic                  xy_zero_w;
  cvec_t                 p0_vec_d, p0_vec_q;
  side1_t                p0_side_d, p0_side_q;
  logic                  p0_valid_q;

  assign sx        = CDW'($signed({in_data_i.coord_x, {FRAC_BITS{1'b0}}}));
  assign sy        = CDW'($signed({in_data_i.coord_y, {FRAC_BITS{1'b0}}}));
  assign xy_zero_w = (in_data_i.coord_x == '0) && (in_data_i.coord_y == '0);

  always_comb begin
    if (in_data_i.coord_x[COORD_BITS-1]) begin
      p0_vec_d.x   = -sx;
      p0_vec_d.y   = -sy;
      p0_vec_d.ang = HALF_TURN;
    end else begin
      p0_vec_d.x   = sx;
      p0_vec_d.y   = sy;
      p0_vec_d.ang = '0;
    end
    p0_side_d.coord_z          = in_data_i.coord_z;
    p0_side_d.xy_zero          = xy_zero_w;
    p0_side_d.origin           = xy_zero_w && (in_data_i.coord_z == '0);
    p0_side_d.attr.reflectance = in_data_i.in_reflectance;
    p0_side_d.attr.amplitude   = in_data_i.in_amplitude;
    p0_side_d.attr.deviation   = in_data_i.in_deviation;
    p0_side_d.attr.last_echo   = in_data_i.in_last_echo;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      p0_valid_q <= 1'b0;
    end else if (en) begin
      p0_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      p0_vec_q  <= p0_vec_d;
      p0_side_q <= p0_side_d;
    end
  end

  // First pass: azimuth and x-y magnitude.
  logic            c1_valid;
  cvec_t           c1_vec;
  logic [S1_W-1:0] c1_side_bits;
  side1_t          c1_side;

  c2s_chain #(
    .STAGES (CORDIC_STAGES),
    .SW     (S1_W)
  ) u_chain_xy (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (p0_valid_q),
    .vec_i   (p0_vec_q),
    .side_i  (p0_side_q),
    .valid_o (c1_valid),
    .vec_o   (c1_vec),
    .side_o  (c1_side_bits)
  );

  assign c1_side = c1_side_bits;

  // Gain correction split into two partial products; z folded to z >= 0.
  logic [19:0]           mag_hi, mag_lo;
  logic [43:0]           m1_ph_d, m1_pl_d, m1_ph_q, m1_pl_q;
  logic [COORD_BITS:0]   cz_ext, cz_abs;
  logic signed [CDW-1:0] m1_zsc_d, m1_zsc_q;
  logic                  m1_zneg_q;
  side2_t                m1_side_d, m1_side_q;
  logic                  m1_valid_q;

  assign mag_hi   = c1_vec.x[39:20];
  assign mag_lo   = c1_vec.x[19:0];
  assign m1_ph_d  = mag_hi * ATAN_KINV;
  assign m1_pl_d  = mag_lo * ATAN_KINV;
  assign cz_ext   = {c1_side.coord_z[COORD_BITS-1], c1_side.coord_z};
  assign cz_abs   = c1_side.coord_z[COORD_BITS-1] ? (~cz_ext + 1'b1) : cz_ext;
  assign m1_zsc_d = CDW'({cz_abs, {FRAC_BITS{1'b0}}});

  always_comb begin
    m1_side_d.az_ang  = c1_vec.ang;
    m1_side_d.xy_zero = c1_side.xy_zero;
    m1_side_d.origin  = c1_side.origin;
    m1_side_d.attr    = c1_side.attr;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m1_valid_q <= 1'b0;
    end else if (en) begin
      m1_valid_q <= c1_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      m1_ph_q   <= m1_ph_d;
      m1_pl_q   <= m1_pl_d;
      m1_zsc_q  <= m1_zsc_d;
      m1_zneg_q <= c1_side.coord_z[COORD_BITS-1];
      m1_side_q <= m1_side_d;
    end
  end

  // Second pass set-up: rounded rho, and a quarter turn for negative z.
  logic [63:0]           rho_sum;
  logic signed [CDW-1:0] rho;
  cvec_t                 m2_vec_d, m2_vec_q;
  side2_t                m2_side_q;
  logic                  m2_valid_q;

  assign rho_sum = {m1_ph_q, 20'd0} + 64'(m1_pl_q) + 64'h80_0000;
  assign rho     = CDW'(rho_sum[63:24]);

  always_comb begin
    if (m1_zneg_q) begin
      m2_vec_d.x   = rho;
      m2_vec_d.y   = m1_zsc_q;
      m2_vec_d.ang = QUARTER_TURN;
    end else begin
      m2_vec_d.x   = m1_zsc_q;
      m2_vec_d.y   = rho;
      m2_vec_d.ang = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m2_valid_q <= 1'b0;
    end else if (en) begin
      m2_valid_q <= m1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      m2_vec_q  <= m2_vec_d;
      m2_side_q <= m1_side_q;
    end
  end

  // Second pass: polar angle and full distance.
  logic            c2_valid;
  cvec_t           c2_vec;
  logic [S2_W-1:0] c2_side_bits;
  side2_t          c2_side;

  c2s_chain #(
    .STAGES (CORDIC_STAGES),
    .SW     (S2_W)
  ) u_chain_zr (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (m2_valid_q),
    .vec_i   (m2_vec_q),
    .side_i  (m2_side_q),
    .valid_o (c2_valid),
    .vec_o   (c2_vec),
    .side_o  (c2_side_bits)
  );

  assign c2_side = c2_side_bits;

  // Output scaling products.
  logic [ANG_W-1:0]     pol_ang;
  logic [HI_W-1:0]      dist_hi;
  logic [FRAC_BITS-1:0] dist_lo;
  logic [55:0]          f1_azp_d, f1_polp_d, f1_azp_q, f1_polp_q;
  logic [HP_W-1:0]      f1_hp_d, f1_hp_q;
  logic [LP_W-1:0]      f1_lp_d, f1_lp_q;
  side2_t               f1_side_q;
  logic                 f1_valid_q;

  always_comb begin
    if (c2_vec.ang >= WRAP_LIMIT) begin
      pol_ang = '0;
    end else if (c2_vec.ang > HALF_TURN) begin
      pol_ang = HALF_TURN;
    end else begin
      pol_ang = c2_vec.ang;
    end
  end

  assign dist_hi   = c2_vec.x[CDW-2:FRAC_BITS];
  assign dist_lo   = c2_vec.x[FRAC_BITS-1:0];
  assign f1_azp_d  = c2_side.az_ang * TURN_OUT;
  assign f1_polp_d = pol_ang * TURN_OUT;
  assign f1_hp_d   = dist_hi * RANGE_SCALE;
  assign f1_lp_d   = dist_lo * RANGE_SCALE;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      f1_valid_q <= 1'b0;
    end else if (en) begin
      f1_valid_q <= c2_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      f1_azp_q  <= f1_azp_d;
      f1_polp_q <= f1_polp_d;
      f1_hp_q   <= f1_hp_d;
      f1_lp_q   <= f1_lp_d;
      f1_side_q <= c2_side;
    end
  end

  // Rounding, wrap and saturation.
  logic [56:0]         az_sum, pol_sum;
  logic [24:0]         az_full;
  logic [DSUM_W-1:0]   dsum, dshift;
  logic [RANGE_W-1:0]  range_sat;
  logic [AZ_W-1:0]     azim;
  out_item_t           tail_d, tail_q;
  logic                tail_valid_q;

  assign az_sum    = {1'b0, f1_azp_q} + 57'h8000_0000;
  assign pol_sum   = {1'b0, f1_polp_q} + 57'h8000_0000;
  assign az_full   = az_sum[56:32];
  assign azim      = (az_full >= 25'(TURN_OUT)) ? '0 : az_full[AZ_W-1:0];
  assign dsum      = DSUM_W'(f1_hp_q) + DSUM_W'(f1_lp_q >> FRAC_BITS)
                     + (DSUM_W'(1) << 23);
  assign dshift    = dsum >> 24;
  assign range_sat = (dshift > DSUM_W'({RANGE_W{1'b1}})) ? {RANGE_W{1'b1}}
                                                          : RANGE_W'(dshift);

  always_comb begin
    tail_d.range_out       = f1_side_q.origin ? '0 : range_sat;
    tail_d.azimuth_out     = f1_side_q.xy_zero ? '0 : azim;
    tail_d.polar_out       = f1_side_q.origin ? '0 : pol_sum[54:32];
    tail_d.out_reflectance = f1_side_q.attr.reflectance;
    tail_d.out_amplitude   = f1_side_q.attr.amplitude;
    tail_d.out_deviation   = f1_side_q.attr.deviation;
    tail_d.out_last_echo   = f1_side_q.attr.last_echo;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tail_valid_q <= 1'b0;
    end else if (en) begin
      tail_valid_q <= f1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      tail_q <= tail_d;
    end
  end

  // Output register with skid: a result that cannot leave is parked and the
  // pipeline holds until it has gone.
  out_item_t out_q, skid_q;
  logic      out_valid_q;
  logic      out_free;

  assign out_free = !out_valid_q || !out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else if (skid_valid_q) begin
      if (out_free) begin
        out_valid_q  <= 1'b1;
        skid_valid_q <= 1'b0;
      end
    end else if (tail_valid_q) begin
      if (out_free) begin
        out_valid_q <= 1'b1;
      end else begin
        skid_valid_q <= 1'b1;
      end
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (skid_valid_q) begin
      if (out_free) begin
        out_q <= skid_q;
      end
    end else if (tail_valid_q) begin
      if (out_free) begin
        out_q <= tail_q;
      end else begin
        skid_q <= tail_q;
      end
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

### bench/cartesian_to_spherical_degrees_core_tb.sv
// ----------------------------------------------------------------------------
// Testbench for the cartesian to spherical converter core
// Echo points go in as requests through a bursty driver, and results are taken
// under a shifting stall pattern. Each result is checked field by field against
// an in-order store of predicted range, azimuth, polar angle and attributes.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module cartesian_to_spherical_degrees_core_tb
  import c2s_pkg::*;
();

  localparam int N_STAGES     = 24;
  localparam int FRAC         = 14;
  localparam int N_RANDOM     = 1000;
  localparam int IDLE_LIMIT   = 2000;
  localparam int SETTLE_TICKS = 2 * N_STAGES + 5 + 20;

  localparam logic [31:0]     HALF_REV    = 32'h8000_0000;
  localparam logic [31:0]     QUARTER_REV = 32'h4000_0000;
  localparam logic [31:0]     NEG_REV     = 32'hC000_0000;
  localparam logic [31:0]     TURN_CENTI  = 32'd9216000;
  localparam longint unsigned KINV_Q24    = 64'd10188014;
  localparam longint unsigned RANGE_MUL   = 64'd260813150;
  localparam longint unsigned RANGE_MAX   = 64'h1FFF_FFFF;

  localparam logic [31:0] ARCTAN [N_STAGES] = '{
    32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756,
    32'd42667331,  32'd21354465,  32'd10679838,  32'd5340245,
    32'd2670163,   32'd1335087,   32'd667544,    32'd333772,
    32'd166886,    32'd83443,     32'd41722,     32'd20861,
    32'd10430,     32'd5215,      32'd2608,      32'd1304,
    32'd652,       32'd326,       32'd163,       32'd81
  };

  typedef enum logic [1:0] {
    FLOW_FREE,
    FLOW_LIGHT,
    FLOW_HALF,
    FLOW_HEAVY
  } flow_mode_e;

  logic      clk       = 1'b0;
  logic      rst_n     = 1'b0;
  logic      in_valid  = 1'b0;
  logic      in_stall;
  in_item_t  in_data   = '0;
  logic      out_valid;
  logic      out_stall = 1'b0;
  out_item_t out_data;

  in_item_t   point_q[$];
  out_item_t  expected_q[$];
  int         err_count    = 0;
  int         points_taken = 0;
  int         results_done = 0;
  int         pause_a      = -1;
  int         pause_b      = -1;
  int         burst_left   = 0;
  int         gap_left     = 0;
  int         seg_left     = 0;
  int         idle_cycles  = 0;
  flow_mode_e flow_mode    = FLOW_FREE;

  cartesian_to_spherical_degrees_core dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_data_o  (out_data)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Rotates (a, b) onto the positive a axis, floor shifts throughout.
  function automatic logic [31:0] vector_to_axis(inout longint a, inout longint b,
                                                 input logic [31:0] ang);
    longint da;
    longint db;
    int     k;
    for (k = 0; k < N_STAGES; k++) begin
      da = b >>> k;
      db = a >>> k;
      if (b >= 0) begin
        a   = a + da;
        b   = b - db;
        ang = ang + ARCTAN[k];
      end else begin
        a   = a - da;
        b   = b + db;
        ang = ang - ARCTAN[k];
      end
    end
    return ang;
  endfunction

  function automatic logic [31:0] turns_to_centidegrees(input logic [31:0] ang);
    logic [63:0] prod;
    prod = {32'd0, ang} * 64'd9216000 + 64'h8000_0000;
    return prod[63:32];
  endfunction

  function automatic out_item_t spherical_of(input in_item_t p);
    longint          cx;
    longint          cy;
    longint          cz;
    longint          a;
    longint          b;
    longint unsigned rho;
    longint unsigned hi;
    longint unsigned lo;
    longint unsigned span;
    logic [31:0]     ang;
    logic [31:0]     deg;
    out_item_t       r;
    cx = $signed(p.coord_x);
    cy = $signed(p.coord_y);
    cz = $signed(p.coord_z);
    r = '0;
    r.out_reflectance = p.in_reflectance;
    r.out_amplitude   = p.in_amplitude;
    r.out_deviation   = p.in_deviation;
    r.out_last_echo   = p.in_last_echo;
    if (cx != 0 || cy != 0 || cz != 0) begin
      rho = 0;
      if (cx != 0 || cy != 0) begin
        a   = cx <<< FRAC;
        b   = cy <<< FRAC;
        ang = '0;
        if (a < 0) begin
          a   = -a;
          b   = -b;
          ang = HALF_REV;
        end
        ang = vector_to_axis(a, b, ang);
        deg = turns_to_centidegrees(ang);
        r.azimuth_out = (deg >= TURN_CENTI) ? '0 : deg[23:0];
        rho = a;
        rho = (rho * KINV_Q24 + 64'h80_0000) >> 24;
      end
      if (cz < 0) begin
        a   = rho;
        b   = -cz <<< FRAC;
        ang = QUARTER_REV;
      end else begin
        a   = cz <<< FRAC;
        b   = rho;
        ang = '0;
      end
      ang = vector_to_axis(a, b, ang);
      if (ang >= NEG_REV) begin
        ang = '0;
      end else if (ang > HALF_REV) begin
        ang = HALF_REV;
      end
      deg = turns_to_centidegrees(ang);
      r.polar_out = deg[22:0];
      hi   = a;
      lo   = hi & ((64'd1 << FRAC) - 64'd1);
      hi   = hi >> FRAC;
      span = (hi * RANGE_MUL + ((lo * RANGE_MUL) >> FRAC) + 64'h80_0000) >> 24;
      r.range_out = (span > RANGE_MAX) ? RANGE_MAX[28:0] : span[28:0];
    end
    return r;
  endfunction

  task automatic flag_error(input string what);
    $display("ERROR at %0t: %s", $time, what);
    err_count++;
  endtask

  task automatic check_field(input string name, input int idx,
                             input logic [31:0] got, input logic [31:0] want);
    if (got !== want) begin
      flag_error($sformatf("result %0d %s got 0x%0h expected 0x%0h",
                           idx, name, got, want));
    end
  endtask

  task automatic add_point(input int x, input int y, input int z, input int refl,
                           input int amp, input int dev, input bit last);
    in_item_t p;
    p.coord_x        = x[23:0];
    p.coord_y        = y[23:0];
    p.coord_z        = z[23:0];
    p.in_reflectance = refl[15:0];
    p.in_amplitude   = amp[15:0];
    p.in_deviation   = dev[15:0];
    p.in_last_echo   = last;
    point_q = {point_q, p};
  endtask

  // Mostly full-range values, with zeros, extremes and narrowed magnitudes mixed in.
  function automatic logic signed [23:0] rand_coord();
    logic [31:0]        bits;
    logic signed [23:0] v;
    bits = $urandom;
    v = bits[23:0];
    case ($urandom_range(0, 9))
      0: v = '0;
      1: v = bits[0] ? 24'sh7F_FFFF : 24'sh80_0000;
      2, 3: v = v >>> $urandom_range(1, 23);
      default: ;
    endcase
    return v;
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        expected_q = {expected_q, spherical_of(in_data)};
      end
      if (!in_valid || !in_stall) begin
        if (gap_left > 0 || point_q.size() == 0 ||
            ((points_taken == pause_a || points_taken == pause_b) &&
             results_done != points_taken)) begin
          in_valid <= 1'b0;
          if (gap_left > 0) begin
            gap_left <= gap_left - 1;
          end
        end else begin
          in_valid <= 1'b1;
          in_data  <= point_q.pop_front();
          points_taken++;
          if (burst_left <= 1) begin
            burst_left <= $urandom_range(1, 24);
            gap_left   <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
          end else begin
            burst_left <= burst_left - 1;
          end
        end
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      if (seg_left == 0) begin
        seg_left  <= $urandom_range(8, 120);
        flow_mode <= flow_mode_e'($urandom_range(0, 3));
      end else begin
        seg_left <= seg_left - 1;
      end
      case (flow_mode)
        FLOW_FREE:  out_stall <= 1'b0;
        FLOW_LIGHT: out_stall <= ($urandom_range(0, 3) == 0);
        FLOW_HALF:  out_stall <= ($urandom_range(0, 1) == 0);
        default:    out_stall <= ($urandom_range(0, 7) != 0);
      endcase
    end
  end

  always @(posedge clk) begin
    out_item_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (expected_q.size() == 0) begin
        flag_error($sformatf("result %0d arrived with nothing outstanding",
                             results_done));
      end else begin
        want = expected_q.pop_front();
        check_field("range", results_done, 32'(out_data.range_out), 32'(want.range_out));
        check_field("azimuth", results_done, 32'(out_data.azimuth_out),
                    32'(want.azimuth_out));
        check_field("polar", results_done, 32'(out_data.polar_out), 32'(want.polar_out));
        check_field("reflectance", results_done, 32'(unsigned'(out_data.out_reflectance)),
                    32'(unsigned'(want.out_reflectance)));
        check_field("amplitude", results_done, 32'(unsigned'(out_data.out_amplitude)),
                    32'(unsigned'(want.out_amplitude)));
        check_field("deviation", results_done, 32'(out_data.out_deviation),
                    32'(want.out_deviation));
        check_field("last echo", results_done, 32'(out_data.out_last_echo),
                    32'(want.out_last_echo));
      end
      results_done <= results_done + 1;
    end
  end

  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("cartesian_to_spherical_degrees_core_tb NOT OK");
      $finish;
    end
  end

  initial begin
    in_item_t    p;
    logic [31:0] bits;
    int          n;

    add_point(0, 0, 0, 32767, -32768, 65535, 1'b1);
    add_point(0, 0, 0, -32768, 32767, 0, 1'b0);
    add_point(0, 0, 8388607, 0, 0, 1, 1'b1);
    add_point(0, 0, -8388608, -1, -1, 65535, 1'b0);
    add_point(0, 0, 1, 1, 1, 32768, 1'b1);
    add_point(0, 0, -1, 32767, 32767, 0, 1'b0);
    add_point(1, 0, 0, -32768, -32768, 65535, 1'b1);
    add_point(-1, 0, 0, 100, -100, 1234, 1'b0);
    add_point(0, 1, 0, -2000, 1500, 4321, 1'b1);
    add_point(0, -1, 0, 5, 6, 7, 1'b0);
    add_point(-8388608, 0, 0, 32767, -32768, 0, 1'b1);
    add_point(8388607, -1, 0, -32768, 32767, 65535, 1'b0);
    add_point(8388607, 8388607, 8388607, 32767, 32767, 65535, 1'b1);
    add_point(-8388608, -8388608, -8388608, -32768, -32768, 0, 1'b0);
    add_point(8388607, -8388608, 0, 0, 0, 0, 1'b1);
    add_point(-8388608, 8388607, 0, -1, 0, 65535, 1'b0);
    add_point(-8388608, 8388607, -8388608, 12345, -12345, 54321, 1'b1);
    add_point(1, 1, -1, -7, 7, 9, 1'b0);
    add_point(3, 4, 12, 300, 400, 500, 1'b1);
    add_point(-5, -7, 9, -300, -400, 600, 1'b0);
    add_point(1000, -2000, -3000, 32000, -32000, 60000, 1'b1);
    add_point(-8388608, -1, 8388607, -32768, 32767, 1, 1'b0);
    pause_a = point_q.size();
    pause_b = pause_a + N_RANDOM / 2;

    for (n = 0; n < N_RANDOM; n++) begin
      p.coord_x = rand_coord();
      p.coord_y = rand_coord();
      p.coord_z = rand_coord();
      bits = $urandom;
      p.in_reflectance = bits[15:0];
      p.in_amplitude   = bits[31:16];
      bits = $urandom;
      p.in_deviation   = bits[15:0];
      p.in_last_echo   = bits[16];
      point_q = {point_q, p};
    end

    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    @(posedge clk);
    while (point_q.size() != 0 || in_valid || results_done != points_taken) begin
      @(posedge clk);
    end
    repeat (SETTLE_TICKS) @(posedge clk);

    if (expected_q.size() != 0) begin
      flag_error($sformatf("%0d results never arrived", expected_q.size()));
    end
    if (err_count == 0) begin
      $display("cartesian_to_spherical_degrees_core_tb OK");
    end else begin
      $display("cartesian_to_spherical_degrees_core_tb NOT OK");
    end
    $finish;
  end

endmodule
